### hw/rtl/qau_pkg.sv
// Shared widths, operation and status codes, and the word formats that
// travel down the square-root and divider cell chains. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

   localparam int COMP_W     = 16;  // component width, signed Q3.12
   localparam int FRAC_W     = 12;  // fraction bits of a component
   localparam int DOT_W      = 32;  // dot product width, signed Q7.24
   localparam int STATUS_W   = 2;
   localparam int LANES      = 4;   // x, y, z, w
   localparam int LSQ_W      = 33;  // squared length of A, unsigned
   localparam int SHIFT_W    = 5;   // pair shift that normalizes the radicand
   localparam int RAD_W      = 64;  // normalized radicand
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SREM_W     = ROOT_W + 1;
   localparam int QUO_W      = COMP_W + 1;  // enough to tell cap from cap + 1
   localparam int SQRT_CELLS = ROOT_W;
   localparam int DIV_CELLS  = QUO_W;

   typedef enum logic [2:0] {
      OP_NORMALIZE = 3'd0,
      OP_CONJUGATE = 3'd1,
      OP_INVERSE   = 3'd2,
      OP_DOT       = 3'd3,
      OP_MULTIPLY  = 3'd4,
      OP_ROTATE    = 3'd5
   } op_type;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

   typedef logic [COMP_W-1:0] comp_type;

   // Result in progress. For normalize and inverse, r holds A until the
   // divider lanes replace it.
   typedef struct packed {
      logic                      use_div;
      logic                      inv;
      comp_type [LANES-1:0]      r;
      logic [DOT_W-1:0]          dot;
      logic [STATUS_W-1:0]       status;
      logic [LSQ_W-1:0]          len_sq;
      logic [SHIFT_W-1:0]        shift;
   } carry_type;

   typedef struct packed {
      logic                      valid;
      carry_type                 carry;
      logic [SREM_W-1:0]         rem;
      logic [ROOT_W-1:0]         root;
      logic [RAD_W-1:0]          rad;
   } sq_type;

   typedef struct packed {
      logic                          valid;
      carry_type                     carry;
      logic [LSQ_W-1:0]              divisor;
      logic [LANES-1:0][LSQ_W-1:0]   rem;
      logic [LANES-1:0][QUO_W-1:0]   quo;
      logic [LANES-1:0]              over;
      logic [LANES-1:0]              neg;
   } dv_type;

endpackage

`default_nettype wire

### hw/rtl/quaternion_arithmetic_unit.sv
// Top level of the fixed-point quaternion ALU: product front end, square
// root cell chain, divider cell chain. Depends on qau_pkg, qau_sqrt_cell,
// qau_div_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// request   in         start high, busy low  req_operation, req_a_*, req_b_*
// response  out        rsp_strobe, 1 cycle   rsp_r_*, rsp_dot_value, rsp_status
//
// One word is taken every cycle; busy never rises.
// Every operation takes the same path: five product and sum stages, a
// radicand setup stage, 32 square-root cells (one root bit each), a divider
// setup stage, 17 divider cells (one quotient bit each) and the output
// register. The long cell chains set the latency; the rate is one word a
// cycle. Reset clears only the valid bits; the receiver cannot stall.

module quaternion_arithmetic_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_operation,
   input  logic signed [15:0]            req_a_x,
   input  logic signed [15:0]            req_a_y,
   input  logic signed [15:0]            req_a_z,
   input  logic signed [15:0]            req_a_w,
   input  logic signed [15:0]            req_b_x,
   input  logic signed [15:0]            req_b_y,
   input  logic signed [15:0]            req_b_z,
   input  logic signed [15:0]            req_b_w,
   output logic                          rsp_strobe,
   output logic signed [15:0]            rsp_r_x,
   output logic signed [15:0]            rsp_r_y,
   output logic signed [15:0]            rsp_r_z,
   output logic signed [15:0]            rsp_r_w,
   output logic signed [31:0]            rsp_dot_value,
   output logic [1:0]                    rsp_status
);
   import qau_pkg::*;

   localparam int PROD_W  = 2 * COMP_W;      // component product
   localparam int SUM_W   = PROD_W + 2;      // sum of four products
   localparam int CROSS_W = 22;              // rounded q x v component
   localparam int AC_W    = COMP_W + CROSS_W;
   localparam int ROT_W   = AC_W + 4;        // rotate accumulator
   localparam int WIDE_W  = 48;
   localparam int INV_PRE  = 2 * FRAC_W - QUO_W;
   localparam int NORM_PRE = QUO_W - FRAC_W;

   localparam logic signed [WIDE_W-1:0] HALF_LSB = 48'sd1 <<< (FRAC_W - 1);
   localparam logic signed [WIDE_W-1:0] CMAX = (48'sd1 <<< (COMP_W - 1)) - 48'sd1;
   localparam logic signed [WIDE_W-1:0] CMIN = -(48'sd1 <<< (COMP_W - 1));
   localparam logic signed [WIDE_W-1:0] DMAX = (48'sd1 <<< (DOT_W - 1)) - 48'sd1;
   localparam logic signed [WIDE_W-1:0] DMIN = -(48'sd1 <<< (DOT_W - 1));
   localparam logic [QUO_W:0] QPOS_MAX = (QUO_W + 1)'(CMAX);
   localparam logic [QUO_W:0] QNEG_MAX = QPOS_MAX + 1'b1;

   typedef struct packed {
      logic                                 valid;
      op_type                               op;
      comp_type [LANES-1:0]                 a;
      comp_type [LANES-1:0]                 b;
      logic [LANES-1:0][LANES-1:0][PROD_W-1:0] pab;
      logic [LANES-1:0][PROD_W-1:0]         paa;
   } s1_type;

   typedef struct packed {
      logic                         valid;
      op_type                       op;
      comp_type [LANES-1:0]         a;
      comp_type [LANES-1:0]         b;
      logic [LANES-1:0][SUM_W-1:0]  t;
      logic [SUM_W-1:0]             dot;
      logic [LSQ_W-1:0]             lsq;
      logic [2:0][SUM_W-1:0]        cr;
   } s2_type;

   typedef struct packed {
      logic                         valid;
      op_type                       op;
      comp_type [LANES-1:0]         a;
      comp_type [2:0]               b;
      logic [2:0][CROSS_W-1:0]      c;
      carry_type                    carry;
   } s3_type;

   typedef struct packed {
      logic                         valid;
      op_type                       op;
      comp_type [2:0]               b;
      logic [2:0][AC_W-1:0]         xp;
      logic [2:0][AC_W-1:0]         xn;
      logic [2:0][AC_W-1:0]         wc;
      carry_type                    carry;
   } s4_type;

   typedef struct packed {
      logic                         valid;
      op_type                       op;
      logic [2:0][ROT_W-1:0]        tr;
      carry_type                    carry;
   } s5_type;

   function automatic logic [PROD_W-1:0] mul_comp(input comp_type x, input comp_type y);
      logic signed [PROD_W-1:0] p;
      p = $signed(x) * $signed(y);
      return p;
   endfunction

   function automatic logic [AC_W-1:0] mul_cross(input comp_type x,
                                                  input logic [CROSS_W-1:0] y);
      logic signed [AC_W-1:0] p;
      p = $signed(x) * $signed(y);
      return p;
   endfunction

   // round half up, then floor back to the component scale
   function automatic logic signed [WIDE_W-1:0] round_frac(
      input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] s;
      s = v + HALF_LSB;
      return s >>> FRAC_W;
   endfunction

   function automatic comp_type sat_comp(input logic signed [WIDE_W-1:0] v);
      comp_type res;
      if (v > CMAX) begin
         res = CMAX[COMP_W-1:0];
      end else if (v < CMIN) begin
         res = CMIN[COMP_W-1:0];
      end else begin
         res = v[COMP_W-1:0];
      end
      return res;
   endfunction

   function automatic logic over_comp(input logic signed [WIDE_W-1:0] v);
      return (v > CMAX) || (v < CMIN);
   endfunction

   comp_type [LANES-1:0] req_a;
   comp_type [LANES-1:0] req_b;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   s5_type s5_in, s5_ff;
   sq_type sq_head_in, sq_head_ff;
   dv_type dv_head_in, dv_head_ff;

   sq_type sq_link [0:SQRT_CELLS];
   dv_type dv_link [0:DIV_CELLS];

   // stage 2 work
   logic signed [SUM_W-1:0] pp [LANES][LANES];

   // stage 3 work
   logic signed [WIDE_W-1:0] hr [LANES];
   logic signed [WIDE_W-1:0] cn [3];
   logic signed [WIDE_W-1:0] dot_w;
   logic [LANES-1:0]         h_hit;
   logic [2:0]               c_hit;
   comp_type [LANES-1:0]     h_val;
   comp_type [LANES-1:0]     conj_val;
   logic                     d_hit;
   logic [5:0]               msb;
   logic [5:0]               pair_gap;
   logic                     len_zero;

   // stage 5 and 6 work
   logic signed [ROT_W-1:0]  bs [3];
   logic signed [ROT_W-1:0]  dd [3];
   logic signed [WIDE_W-1:0] rr [3];
   logic [2:0]               r_hit;
   logic [RAD_W-1:0]         rad_base;

   // divider setup work
   logic signed [COMP_W:0]            ae [LANES];
   logic [LANES-1:0][COMP_W:0]        mag;
   logic [LANES-1:0][43:0]            pre;
   logic [LSQ_W-1:0]                  dsel;
   logic [SHIFT_W-1:0]                norm_sh;

   // final stage work
   logic [LANES-1:0]                  rnd;
   logic [LANES-1:0][QUO_W:0]         qf;
   logic [LANES-1:0]                  q_hit;
   comp_type [LANES-1:0]              q_val;

   logic                              out_valid_ff;
   comp_type [LANES-1:0]              out_r_ff, out_r_in;
   logic [DOT_W-1:0]                  out_dot_ff, out_dot_in;
   logic [STATUS_W-1:0]               out_status_ff, out_status_in;

   assign busy  = 1'b0;
   assign req_a = {req_a_w, req_a_z, req_a_y, req_a_x};
   assign req_b = {req_b_w, req_b_z, req_b_y, req_b_x};

   // Stage 1: every component product in one bank of multipliers.
   always_comb begin
      s1_in.valid = start && !reset;
      s1_in.op    = op_type'(req_operation);
      s1_in.a     = req_a;
      s1_in.b     = req_b;
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            s1_in.pab[i][j] = mul_comp(req_a[i], req_b[j]);
         end
         s1_in.paa[i] = mul_comp(req_a[i], req_a[i]);
      end
   end

   // Stage 2: Hamilton sums, dot sum, squared length, raw q x v.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            pp[i][j] = $signed(s1_ff.pab[i][j]);
         end
      end
      s2_in.valid = s1_ff.valid && !reset;
      s2_in.op    = s1_ff.op;
      s2_in.a     = s1_ff.a;
      s2_in.b     = s1_ff.b;
      s2_in.t[0]  = pp[3][0] + pp[0][3] + pp[1][2] - pp[2][1];
      s2_in.t[1]  = pp[3][1] - pp[0][2] + pp[1][3] + pp[2][0];
      s2_in.t[2]  = pp[3][2] + pp[0][1] - pp[1][0] + pp[2][3];
      s2_in.t[3]  = pp[3][3] - pp[0][0] - pp[1][1] - pp[2][2];
      s2_in.dot   = pp[0][0] + pp[1][1] + pp[2][2] + pp[3][3];
      s2_in.lsq   = LSQ_W'(s1_ff.paa[0]) + LSQ_W'(s1_ff.paa[1])
                  + LSQ_W'(s1_ff.paa[2]) + LSQ_W'(s1_ff.paa[3]);
      s2_in.cr[0] = pp[1][2] - pp[2][1];
      s2_in.cr[1] = pp[2][0] - pp[0][2];
      s2_in.cr[2] = pp[0][1] - pp[1][0];
   end

   // Stage 3: round and clamp the product results, conjugate, clamp the
   // dot sum, round q x v, find the pair shift for the radicand.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         hr[i]    = round_frac($signed(s2_ff.t[i]));
         h_val[i] = sat_comp(hr[i]);
         h_hit[i] = over_comp(hr[i]);
      end
      for (int i = 0; i < 3; i++) begin
         cn[i]       = -$signed(s2_ff.a[i]);
         conj_val[i] = sat_comp(cn[i]);
         c_hit[i]    = over_comp(cn[i]);
      end
      conj_val[3] = s2_ff.a[3];
      dot_w = $signed(s2_ff.dot);
      d_hit = (dot_w > DMAX) || (dot_w < DMIN);

      // highest set bit of the squared length; shift pairs up to the top
      msb = 6'd0;
      for (int i = 0; i < LSQ_W; i++) begin
         if (s2_ff.lsq[i]) begin
            msb = 6'(i);
         end
      end
      pair_gap = 6'(RAD_W - 1) - msb;
      len_zero = (s2_ff.lsq == '0);

      s3_in.valid = s2_ff.valid && !reset;
      s3_in.op    = s2_ff.op;
      s3_in.a     = s2_ff.a;
      s3_in.b     = s2_ff.b[2:0];
      for (int i = 0; i < 3; i++) begin
         s3_in.c[i] = CROSS_W'(round_frac($signed(s2_ff.cr[i])));
      end

      s3_in.carry.use_div = ((s2_ff.op == OP_NORMALIZE) || (s2_ff.op == OP_INVERSE))
                            && !len_zero;
      s3_in.carry.inv     = (s2_ff.op == OP_INVERSE);
      s3_in.carry.len_sq  = s2_ff.lsq;
      s3_in.carry.shift   = pair_gap[SHIFT_W:1];
      s3_in.carry.r       = '0;
      s3_in.carry.dot     = '0;
      s3_in.carry.status  = ST_OK;
      case (s2_ff.op)
         OP_NORMALIZE, OP_INVERSE: begin
            if (len_zero) begin
               s3_in.carry.status = ST_ZERO_LEN;
            end else begin
               s3_in.carry.r = s2_ff.a;
            end
         end
         OP_CONJUGATE: begin
            s3_in.carry.r      = conj_val;
            s3_in.carry.status = (|c_hit) ? ST_SATURATED : ST_OK;
         end
         OP_DOT: begin
            if (dot_w > DMAX) begin
               s3_in.carry.dot = DMAX[DOT_W-1:0];
            end else if (dot_w < DMIN) begin
               s3_in.carry.dot = DMIN[DOT_W-1:0];
            end else begin
               s3_in.carry.dot = dot_w[DOT_W-1:0];
            end
            s3_in.carry.status = d_hit ? ST_SATURATED : ST_OK;
         end
         OP_MULTIPLY: begin
            s3_in.carry.r      = h_val;
            s3_in.carry.status = (|h_hit) ? ST_SATURATED : ST_OK;
         end
         default: begin
            // rotate fills in at stage 6; unknown codes stay all zero
         end
      endcase
   end

   // Stage 4: second product bank for rotate, A against rounded q x v.
   // The rounded cross product stays far inside its clamp range here.
   always_comb begin
      s4_in.valid = s3_ff.valid && !reset;
      s4_in.op    = s3_ff.op;
      s4_in.b     = s3_ff.b;
      s4_in.carry = s3_ff.carry;
      s4_in.xp[0] = mul_cross(s3_ff.a[1], s3_ff.c[2]);
      s4_in.xn[0] = mul_cross(s3_ff.a[2], s3_ff.c[1]);
      s4_in.xp[1] = mul_cross(s3_ff.a[2], s3_ff.c[0]);
      s4_in.xn[1] = mul_cross(s3_ff.a[0], s3_ff.c[2]);
      s4_in.xp[2] = mul_cross(s3_ff.a[0], s3_ff.c[1]);
      s4_in.xn[2] = mul_cross(s3_ff.a[1], s3_ff.c[0]);
      for (int i = 0; i < 3; i++) begin
         s4_in.wc[i] = mul_cross(s3_ff.a[3], s3_ff.c[i]);
      end
   end

   // Stage 5: v + 2w(q x v) + 2 q x (q x v) at the doubled scale.
   always_comb begin
      s5_in.valid = s4_ff.valid && !reset;
      s5_in.op    = s4_ff.op;
      s5_in.carry = s4_ff.carry;
      for (int i = 0; i < 3; i++) begin
         bs[i] = $signed(s4_ff.b[i]);
         dd[i] = $signed(s4_ff.xp[i]) - $signed(s4_ff.xn[i]);
         s5_in.tr[i] = (bs[i] <<< FRAC_W) + ($signed(s4_ff.wc[i]) <<< 1)
                     + (dd[i] <<< 1);
      end
   end

   // Stage 6: round and clamp the rotate result, build the radicand.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rr[i]    = round_frac($signed(s5_ff.tr[i]));
         r_hit[i] = over_comp(rr[i]);
      end
      rad_base = RAD_W'(s5_ff.carry.len_sq);

      sq_head_in.valid = s5_ff.valid && !reset;
      sq_head_in.carry = s5_ff.carry;
      sq_head_in.rem   = '0;
      sq_head_in.root  = '0;
      sq_head_in.rad   = rad_base << {s5_ff.carry.shift, 1'b0};
      if (s5_ff.op == OP_ROTATE) begin
         sq_head_in.carry.r[3] = '0;
         for (int i = 0; i < 3; i++) begin
            sq_head_in.carry.r[i] = sat_comp(rr[i]);
         end
         sq_head_in.carry.status = (|r_hit) ? ST_SATURATED : ST_OK;
      end
   end

   // Square-root chain: every word walks all cells; only normalize uses
   // the root.
   assign sq_link[0] = sq_head_ff;

   for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      qau_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (sq_link[g]),
         .link_out (sq_link[g+1])
      );
   end

   // Divider setup: pick divisor and pre-shifted numerator per lane. The
   // numerator's low quotient bits are always zero, so cells shift in zeros.
   always_comb begin
      dsel    = sq_link[SQRT_CELLS].carry.inv ? sq_link[SQRT_CELLS].carry.len_sq
                                               : LSQ_W'(sq_link[SQRT_CELLS].root);
      norm_sh = sq_link[SQRT_CELLS].carry.shift - SHIFT_W'(NORM_PRE);

      dv_head_in.valid   = sq_link[SQRT_CELLS].valid && !reset;
      dv_head_in.carry   = sq_link[SQRT_CELLS].carry;
      dv_head_in.divisor = dsel;
      dv_head_in.quo     = '0;
      for (int i = 0; i < LANES; i++) begin
         ae[i]  = $signed(sq_link[SQRT_CELLS].carry.r[i]);
         mag[i] = (ae[i] < 0) ? (COMP_W + 1)'(-ae[i]) : (COMP_W + 1)'(ae[i]);
         if (sq_link[SQRT_CELLS].carry.inv) begin
            pre[i] = 44'(mag[i]) << INV_PRE;
         end else begin
            pre[i] = 44'(mag[i]) << norm_sh;
         end
         dv_head_in.rem[i]  = pre[i][LSQ_W-1:0];
         dv_head_in.over[i] = (pre[i] >= 44'(dsel));
         // inverse divides the conjugate, so x, y, z flip sign
         if (sq_link[SQRT_CELLS].carry.inv && (i < 3)) begin
            dv_head_in.neg[i] = (ae[i] > 0);
         end else begin
            dv_head_in.neg[i] = (ae[i] < 0);
         end
      end
   end

   assign dv_link[0] = dv_head_ff;

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      qau_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (dv_link[g]),
         .link_out (dv_link[g+1])
      );
   end

   // Final stage: round half away from zero, sign and saturate each lane.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rnd[i] = ({dv_link[DIV_CELLS].rem[i], 1'b0} >= {1'b0, dv_link[DIV_CELLS].divisor});
         qf[i]  = (QUO_W + 1)'(dv_link[DIV_CELLS].quo[i]) + (QUO_W + 1)'(rnd[i]);
         if (dv_link[DIV_CELLS].neg[i]) begin
            q_hit[i] = dv_link[DIV_CELLS].over[i] || (qf[i] > QNEG_MAX);
            q_val[i] = q_hit[i] ? CMIN[COMP_W-1:0]
                                : COMP_W'((QUO_W + 1)'(0) - qf[i]);
         end else begin
            q_hit[i] = dv_link[DIV_CELLS].over[i] || (qf[i] > QPOS_MAX);
            q_val[i] = q_hit[i] ? CMAX[COMP_W-1:0] : COMP_W'(qf[i]);
         end
      end
      out_r_in      = dv_link[DIV_CELLS].carry.r;
      out_dot_in    = dv_link[DIV_CELLS].carry.dot;
      out_status_in = dv_link[DIV_CELLS].carry.status;
      if (dv_link[DIV_CELLS].carry.use_div) begin
         out_r_in      = q_val;
         out_status_in = (|q_hit) ? ST_SATURATED : ST_OK;
      end
   end

   // Advance every stage each cycle; a reset cycle drops the valid bits only.
   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      s2_ff      <= s2_in;
      s3_ff      <= s3_in;
      s4_ff      <= s4_in;
      s5_ff      <= s5_in;
      sq_head_ff <= sq_head_in;
      dv_head_ff <= dv_head_in;
   end

   // Hold the response word for its one strobe cycle.
   always_ff @(posedge clock) begin
      out_r_ff      <= out_r_in;
      out_dot_ff    <= out_dot_in;
      out_status_ff <= out_status_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_link[DIV_CELLS].valid;
      end
   end

   assign rsp_strobe    = out_valid_ff;
   assign rsp_r_x       = out_r_ff[0];
   assign rsp_r_y       = out_r_ff[1];
   assign rsp_r_z       = out_r_ff[2];
   assign rsp_r_w       = out_r_ff[3];
   assign rsp_dot_value = out_dot_ff;
   assign rsp_status    = out_status_ff;

endmodule

`default_nettype wire

### hw/rtl/qau_sqrt_cell.sv
// One digit cell of the square-root chain: takes in one radicand bit pair
// and retires one root bit per cycle. Depends on qau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qau_sqrt_cell (
   input  logic            clock,
   input  logic            reset,
   input  qau_pkg::sq_type link_in,
   output qau_pkg::sq_type link_out
);
   import qau_pkg::*;

   sq_type             stage_in;
   sq_type             stage_ff;
   logic [SREM_W+1:0]  rem_sh;
   logic [SREM_W+1:0]  trial;
   logic               ge;

   always_comb begin
      rem_sh   = {link_in.rem, link_in.rad[RAD_W-1 -: 2]};
      trial    = {1'b0, link_in.root, 2'b01};
      ge       = (rem_sh >= trial);
      stage_in = link_in;
      stage_in.valid = link_in.valid && !reset;
      stage_in.rem  = ge ? SREM_W'(rem_sh - trial) : SREM_W'(rem_sh);
      stage_in.root = {link_in.root[ROOT_W-2:0], ge};
      stage_in.rad  = {link_in.rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign link_out = stage_ff;

endmodule

`default_nettype wire

### hw/rtl/qau_div_cell.sv
// One step cell of the four-lane restoring divider chain: retires one
// quotient bit per lane per cycle. Depends on qau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qau_div_cell (
   input  logic            clock,
   input  logic            reset,
   input  qau_pkg::dv_type link_in,
   output qau_pkg::dv_type link_out
);
   import qau_pkg::*;

   dv_type                     stage_in;
   dv_type                     stage_ff;
   logic [LANES-1:0][LSQ_W:0]  rs;
   logic [LANES-1:0]           ge;

   always_comb begin
      stage_in = link_in;
      stage_in.valid = link_in.valid && !reset;
      for (int i = 0; i < LANES; i++) begin
         rs[i] = {link_in.rem[i], 1'b0};
         ge[i] = (rs[i] >= {1'b0, link_in.divisor});
         stage_in.rem[i] = ge[i] ? LSQ_W'(rs[i] - {1'b0, link_in.divisor})
                                 : LSQ_W'(rs[i]);
         stage_in.quo[i] = {link_in.quo[i][QUO_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign link_out = stage_ff;

endmodule

`default_nettype wire

### tb/qau_checker.sv
// Scoreboard for the quaternion ALU: watches both channels, predicts every
// result word, and compares. Depends on qau_pkg.
`timescale 1ns / 1ps

module qau_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_operation,
   input  logic signed [15:0] req_a_x, req_a_y, req_a_z, req_a_w,
   input  logic signed [15:0] req_b_x, req_b_y, req_b_z, req_b_w,
   input  logic               rsp_strobe,
   input  logic signed [15:0] rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w,
   input  logic signed [31:0] rsp_dot_value,
   input  logic [1:0]         rsp_status,
   output int                 mismatches,
   output int                 outstanding,
   output int                 words_checked
);
   import qau_pkg::*;

   typedef struct packed {
      logic signed [15:0] x, y, z, w;
      logic signed [31:0] dot;
      logic [1:0]         status;
   } quat_result_type;

   quat_result_type result_fifo[$];

   function automatic longint clamp(longint v, int bits, inout bit sat);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1;
         return hi;
      end
      if (v < lo) begin
         sat = 1;
         return lo;
      end
      return v;
   endfunction

   // round half up back to Q.F; >>> on a signed longint floors
   function automatic longint round_fix(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // round(n * 2^sh / d) half away from zero, anything above cap gives cap + 1
   function automatic longint unsigned scaled_quotient(longint unsigned n,
         longint unsigned d, int sh, longint unsigned cap);
      longint unsigned q, r;
      bit up;
      if (d == 0) return cap + 1;
      q = n / d;
      r = n % d;
      if (q > cap) return cap + 1;
      for (int i = 0; i < sh; i++) begin
         up = (r >= d - r);
         r = up ? r - (d - r) : r + r;
         q = q * 2 + (up ? 1 : 0);
         if (q > cap) return cap + 1;
      end
      if (r >= d - r) q++;
      return q;
   endfunction

   function automatic longint signed_quotient(longint num, longint unsigned d,
         int sh, inout bit sat);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = scaled_quotient(mag, d, sh, 64'd1 << (COMP_W - 1));
      return clamp((num < 0) ? -longint'(q) : longint'(q), COMP_W, sat);
   endfunction

   function automatic quat_result_type predict_quat(logic [2:0] op,
         longint a[4], longint b[4]);
      quat_result_type res;
      longint r[4], c[3], d[3], t[4], s;
      longint unsigned lsq, len;
      bit sat;
      int k;
      sat = 0;
      res = '0;
      r = '{0, 0, 0, 0};
      lsq = 0;
      for (int i = 0; i < 4; i++) lsq += longint'(a[i] * a[i]);
      case (op)
         OP_NORMALIZE: begin
            if (lsq == 0) begin
               res.status = ST_ZERO_LEN;
            end else begin
               k = 0;
               while (k < 31 && (lsq >> 62) == 0) begin
                  lsq = lsq << 2;
                  k++;
               end
               len = root64(lsq);
               for (int i = 0; i < 4; i++) r[i] = signed_quotient(a[i], len, FRAC_W + k, sat);
            end
         end
         OP_CONJUGATE: begin
            for (int i = 0; i < 3; i++) r[i] = clamp(-a[i], COMP_W, sat);
            r[3] = a[3];
         end
         OP_INVERSE: begin
            if (lsq == 0) begin
               res.status = ST_ZERO_LEN;
            end else begin
               for (int i = 0; i < 3; i++) r[i] = signed_quotient(-a[i], lsq, 2 * FRAC_W, sat);
               r[3] = signed_quotient(a[3], lsq, 2 * FRAC_W, sat);
            end
         end
         OP_DOT: begin
            s = 0;
            for (int i = 0; i < 4; i++) s += a[i] * b[i];
            res.dot = 32'(clamp(s, DOT_W, sat));
         end
         OP_MULTIPLY: begin
            t[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
            t[1] = a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0];
            t[2] = a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3];
            t[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
            for (int i = 0; i < 4; i++) r[i] = clamp(round_fix(t[i], FRAC_W), COMP_W, sat);
         end
         OP_ROTATE: begin
            c[0] = a[1]*b[2] - a[2]*b[1];
            c[1] = a[2]*b[0] - a[0]*b[2];
            c[2] = a[0]*b[1] - a[1]*b[0];
            for (int i = 0; i < 3; i++) c[i] = clamp(round_fix(c[i], FRAC_W), 62 - COMP_W, sat);
            d[0] = a[1]*c[2] - a[2]*c[1];
            d[1] = a[2]*c[0] - a[0]*c[2];
            d[2] = a[0]*c[1] - a[1]*c[0];
            for (int i = 0; i < 3; i++) begin
               s = (b[i] <<< FRAC_W) + 2 * (a[3] * c[i]) + 2 * d[i];
               r[i] = clamp(round_fix(s, FRAC_W), COMP_W, sat);
            end
         end
         default: ;
      endcase
      if (res.status == ST_OK && sat) res.status = ST_SATURATED;
      res.x = 16'(r[0]);
      res.y = 16'(r[1]);
      res.z = 16'(r[2]);
      res.w = 16'(r[3]);
      return res;
   endfunction

   always @(posedge clock) begin
      longint a[4], b[4];
      quat_result_type want, got;
      if (reset) begin
         mismatches <= 0;
         words_checked <= 0;
         outstanding <= 0;
         result_fifo.delete();
      end else begin
         if (start && !busy) begin
            a = '{req_a_x, req_a_y, req_a_z, req_a_w};
            b = '{req_b_x, req_b_y, req_b_z, req_b_w};
            result_fifo.push_back(predict_quat(req_operation, a, b));
         end
         if (rsp_strobe) begin
            got = '{rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_dot_value, rsp_status};
            words_checked <= words_checked + 1;
            if (result_fifo.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result word %p", got);
            end else begin
               want = result_fifo.pop_front();
               if (got !== want) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: expected %p, got %p", want, got);
               end
            end
         end
         outstanding <= result_fifo.size();
      end
   end

endmodule

### tb/tb.sv
// Top of the quaternion ALU bench: clock, reset, stimulus and verdict.
// Depends on qau_pkg, qau_checker and the quaternion_arithmetic_unit RTL.
`timescale 1ns / 1ps

module tb;
   import qau_pkg::*;

   localparam int LATENCY     = 57;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1000;
   // the two codes with no operation behind them
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_operation;
   logic signed [15:0] req_a_x, req_a_y, req_a_z, req_a_w;
   logic signed [15:0] req_b_x, req_b_y, req_b_z, req_b_w;
   logic               rsp_strobe;
   logic signed [15:0] rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w;
   logic signed [31:0] rsp_dot_value;
   logic [1:0]         rsp_status;
   int                 mismatches, outstanding, words_checked;
   int                 cycles;
   int                 op_count[8];
   bit                 no_idle;

   quaternion_arithmetic_unit dut (.*);

   qau_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Watchdog: the slowest correct run is far below this.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
         end
      end
   end

   // Drive one word and hold it until the handshake takes it.
   task automatic send_word(logic [2:0] op, logic [15:0] ax, ay, az, aw,
         logic [15:0] bx, by, bz, bw);
      bit taken;
      // idle at random, with odds of 21 in a hundred each draw, except inside the burst stretch
      while (!no_idle && $urandom_range(99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      {req_a_x, req_a_y, req_a_z, req_a_w} <= {ax, ay, az, aw};
      {req_b_x, req_b_y, req_b_z, req_b_w} <= {bx, by, bz, bw};
      op_count[op]++;
      // busy only moves at rising edges, so its value at the falling edge
      // is the one the next rising edge sees
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // Random component: mostly full range, sometimes an extreme or near zero.
   function automatic logic [15:0] pick_comp();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($signed($urandom_range(8)) - 4);
         3:       return 16'($signed($urandom_range(8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [2:0] op;
      logic [15:0] c[8];
      reset = 1'b1;
      start = 1'b0;
      no_idle = 0;
      req_operation = OP_NORMALIZE;
      {req_a_x, req_a_y, req_a_z, req_a_w} = '0;
      {req_b_x, req_b_y, req_b_z, req_b_w} = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero length, extremes, unit values, every operation.
      send_word(OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0, 0);
      send_word(OP_INVERSE,   0, 0, 0, 0, 0, 0, 0, 0);
      send_word(OP_NORMALIZE, 0, 0, 0, 1, 0, 0, 0, 0);
      send_word(OP_NORMALIZE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
      send_word(OP_NORMALIZE, 16'h7FFF, 0, 0, 0, 0, 0, 0, 0);
      send_word(OP_CONJUGATE, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 0, 0, 0, 0);
      send_word(OP_INVERSE,   0, 0, 0, 1, 0, 0, 0, 0);
      send_word(OP_INVERSE,   1, 16'hFFFF, 0, 0, 0, 0, 0, 0);
      send_word(OP_INVERSE,   0, 0, 0, 16'h1000, 0, 0, 0, 0);
      send_word(OP_INVERSE,   16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0);
      send_word(OP_DOT, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(OP_DOT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(OP_DOT, 16'h1000, 0, 0, 0, 16'h1000, 0, 0, 0);
      send_word(OP_MULTIPLY, 0, 0, 0, 16'h1000, 16'h1234, 16'hE000, 16'h0F00, 16'hF001);
      send_word(OP_MULTIPLY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_word(OP_MULTIPLY, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
      send_word(OP_ROTATE, 0, 0, 16'h0B50, 16'h0B50, 16'h1000, 0, 0, 16'h7FFF);
      send_word(OP_ROTATE, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                16'h7FFF, 16'h8000, 16'h7FFF, 0);
      send_word(OP_ROTATE, 0, 0, 0, 16'h1000, 16'h8000, 16'h7FFF, 16'h0001, 0);
      send_word(OP_UNUSED_A, 16'h1000, 1, 2, 3, 4, 5, 6, 7);
      send_word(OP_UNUSED_B, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

      // Hold off until the pipe drains once.
      start <= 1'b0;
      wait (outstanding == 0);
      @(posedge clock);

      // Random words; the middle stretch runs back to back.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_idle = (n >= 400 && n < 600);
         op = ($urandom_range(39) == 0) ? 3'($urandom_range(OP_UNUSED_B, OP_UNUSED_A))
                                        : 3'($urandom_range(OP_ROTATE));
         for (int i = 0; i < 8; i++) c[i] = pick_comp();
         // a few zero quaternions so the zero-length path recurs
         if ($urandom_range(49) == 0) for (int i = 0; i < 4; i++) c[i] = '0;
         send_word(op, c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
      end
      start <= 1'b0;

      wait (outstanding == 0);
      repeat (LATENCY + 10) @(posedge clock);

      $display("checked %0d result words: norm %0d conj %0d inv %0d dot %0d mul %0d rot %0d",
               words_checked, op_count[OP_NORMALIZE], op_count[OP_CONJUGATE],
               op_count[OP_INVERSE], op_count[OP_DOT], op_count[OP_MULTIPLY],
               op_count[OP_ROTATE]);
      $display("unused codes %0d, mismatches %0d",
               op_count[OP_UNUSED_A] + op_count[OP_UNUSED_B], mismatches);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/qau_pkg.sv
hw/rtl/qau_sqrt_cell.sv
hw/rtl/qau_div_cell.sv
hw/rtl/quaternion_arithmetic_unit.sv
tb/qau_checker.sv
tb/tb.sv
